### rtl/core/weno5_pkg.sv
// Shared constants for the WENO5 advection stage update.
`timescale 1ns / 1ps
package weno5_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_COURANT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RK_STAGE = 1'b1;

  localparam logic [16:0] COURANT_RESET = 17'd32768;

  localparam int T_QBITS = 31;
  localparam int W_QBITS = 17;
  localparam int FACE_LAT = 6 + T_QBITS + 3 + W_QBITS + 2;

  localparam logic [15:0] BETA_K = 16'd21843;

  localparam logic [15:0] GAMMA [3] = '{16'd4096, 16'd40960, 16'd20480};

  localparam logic [16:0] ALPHA [4] = '{17'd16384, 17'd21845, 17'd32768, 17'd65536};

endpackage

### rtl/core/weno5_if.sv
// Stream interfaces for the cell window input and the update result.
`timescale 1ns / 1ps
interface weno5_in_if #(parameter int SAMPLE_WIDTH = weno5_pkg::SAMPLE_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] cell_minus3;
  logic signed [SAMPLE_WIDTH-1:0] cell_minus2;
  logic signed [SAMPLE_WIDTH-1:0] cell_minus1;
  logic signed [SAMPLE_WIDTH-1:0] cell_center;
  logic signed [SAMPLE_WIDTH-1:0] cell_plus1;
  logic signed [SAMPLE_WIDTH-1:0] cell_plus2;
  logic signed [SAMPLE_WIDTH-1:0] base_value;
  modport source(output valid, cell_minus3, cell_minus2, cell_minus1, cell_center,
                 cell_plus1, cell_plus2, base_value, input ready);
  modport sink(input valid, cell_minus3, cell_minus2, cell_minus1, cell_center,
               cell_plus1, cell_plus2, base_value, output ready);
endinterface

interface weno5_out_if #(parameter int SAMPLE_WIDTH = weno5_pkg::SAMPLE_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] new_value;
  logic saturated;
  modport source(output valid, new_value, saturated, input ready);
  modport sink(input valid, new_value, saturated, output ready);
endinterface

### rtl/core/weno5_advection_rk_update.sv
// Top level of the WENO5 advection stage update with its configuration registers.
//
//   channel   dir  handshake      payload
//   cells     in   valid/ready    cell_minus3..cell_plus2, base_value
//   result    out  valid/ready    new_value, saturated
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// One transfer is taken per cycle while the result is not stalled. The reconstruction
// runs through two divider chains (31 and 17 bit stages).
// Reset clears all valid bits and restores the configuration registers.
// A stall on the result holds every stage in place; nothing is lost or repeated.
`timescale 1ns / 1ps
module weno5_advection_rk_update #(
  parameter int SAMPLE_WIDTH = weno5_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS = weno5_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  weno5_in_if.sink                             cells,
  weno5_out_if.source                          result,
  input  logic                                 cfg_write,
  input  logic [weno5_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [weno5_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import weno5_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int FW = SW + 9;
  localparam int DFW = FW + 1;
  localparam int MW = FW + 20;
  localparam int RW = FW + 2;
  localparam int TOP_LAT = FACE_LAT + 2;

  logic [16:0] courant;
  logic [1:0]  rk_stage;
  logic        adv;
  logic        vld [TOP_LAT];
  logic signed [SW-1:0] bd [TOP_LAT-1];
  logic signed [SW-1:0] win_r [5];
  logic signed [SW-1:0] win_l [5];
  logic signed [FW-1:0] face_r;
  logic signed [FW-1:0] face_l;
  logic [33:0] scale_full;
  logic [17:0] scale;
  logic signed [DFW-1:0] diff;
  logic signed [MW-1:0] mprod;
  logic signed [RW-1:0] delta;
  logic signed [RW-1:0] upd;
  logic signed [SW-1:0] new_value;
  logic saturated;

  localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      courant <= COURANT_RESET;
      rk_stage <= 2'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COURANT:  courant <= cfg_data;
        REG_RK_STAGE: rk_stage <= cfg_data[1:0];
      endcase
    end
  end

  assign adv = !vld[TOP_LAT-1] || result.ready;
  assign cells.ready = adv;

  assign win_r = '{cells.cell_minus2, cells.cell_minus1, cells.cell_center,
                   cells.cell_plus1, cells.cell_plus2};
  assign win_l = '{cells.cell_minus3, cells.cell_minus2, cells.cell_minus1,
                   cells.cell_center, cells.cell_plus1};

  weno5_face #(.SAMPLE_WIDTH(SW), .FRAC_BITS(FRAC_BITS)) u_face_r (
    .clk(clk), .en(adv), .win(win_r), .face(face_r)
  );
  weno5_face #(.SAMPLE_WIDTH(SW), .FRAC_BITS(FRAC_BITS)) u_face_l (
    .clk(clk), .en(adv), .win(win_l), .face(face_l)
  );

  always_comb begin
    scale_full = 34'(courant) * 34'(ALPHA[rk_stage]);
    scale = 18'((scale_full + 34'd32768) >> 16);
    diff = DFW'(face_r) - DFW'(face_l);
    delta = RW'((mprod + MW'(262144)) >>> 19);
    upd = RW'(bd[TOP_LAT-2]) - delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOP_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= cells.valid;
      for (int i = 1; i < TOP_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bd[0] <= cells.base_value;
      for (int i = 1; i < TOP_LAT - 1; i++) begin
        bd[i] <= bd[i-1];
      end
      mprod <= MW'(diff) * MW'($signed({1'b0, scale}));
      if (upd > MAXV) begin
        new_value <= MAXV[SW-1:0];
        saturated <= 1'b1;
      end else if (upd < MINV) begin
        new_value <= MINV[SW-1:0];
        saturated <= 1'b1;
      end else begin
        new_value <= upd[SW-1:0];
        saturated <= 1'b0;
      end
    end
  end

  assign result.valid = vld[TOP_LAT-1];
  assign result.new_value = new_value;
  assign result.saturated = saturated;

endmodule

### rtl/core/weno5_div.sv
// Pipelined restoring divider, one quotient bit per stage, numerator at most the divisor.
`timescale 1ns / 1ps
module weno5_div #(
  parameter int DENW = 53,
  parameter int QBITS = 31
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DENW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QBITS-1:0] quo
);

  logic [DENW-1:0]  rem [QBITS];
  logic [DENW-1:0]  dv  [QBITS];
  logic [QBITS-1:0] qt  [QBITS];
  logic [DENW:0]    sh  [QBITS];
  logic             ge  [QBITS];

  assign ge[0] = num >= den;
  assign sh[0] = {1'b0, num};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ge[0] ? num - den : num;
      dv[0] <= den;
      qt[0] <= QBITS'(ge[0]);
    end
  end

  for (genvar i = 1; i < QBITS; i++) begin : g_stage
    assign sh[i] = {rem[i-1], 1'b0};
    assign ge[i] = sh[i] >= {1'b0, dv[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge[i] ? DENW'(sh[i] - {1'b0, dv[i-1]}) : DENW'(sh[i]);
        dv[i] <= dv[i-1];
        qt[i] <= {qt[i-1][QBITS-2:0], ge[i]};
      end
    end
  end

  assign quo = qt[QBITS-1];

endmodule

### rtl/core/weno5_face.sv
// Pipelined five-point WENO reconstruction of one face value, in eighths of a sample.
`timescale 1ns / 1ps
module weno5_face #(
  parameter int SAMPLE_WIDTH = weno5_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS = weno5_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] win [5],
  output logic signed [SAMPLE_WIDTH+8:0] face
);
  import weno5_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int DS = (SW > 24) ? SW - 24 : 0;
  localparam int BFRAC = 2 * (FRAC_BITS - DS);
  localparam int DW = SW + 5;
  localparam int PW = SW + 5;
  localparam int EW = SW + 3 - DS;
  localparam int SQW = 2 * EW;
  localparam int SVW = 2 * EW + 1;
  localparam int QW = SVW - 2;
  localparam int DVW = (QW > 33) ? QW : 33;
  localparam int UW = 46;
  localparam int SUMW = 47;
  localparam int FW = PW + 4;
  localparam int PRW = PW + 18;
  localparam int ACW = PW + 20;
  localparam int PD = 6 + T_QBITS + 3 + W_QBITS;
  localparam logic signed [DW-1:0] DRND = (DW'(1) << DS) >> 1;
  localparam longint unsigned EPS_RAW = ((64'd1 << BFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [QW-1:0] EPS = (EPS_RAW == 0) ? QW'(1) : QW'(EPS_RAW);

  logic signed [DW-1:0] xv [5];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [DW-1:0] r1 [3];
  logic signed [DW-1:0] r2 [3];
  logic [DW-1:0]        a1 [3];
  logic [DW-1:0]        a2 [3];
  logic signed [PW-1:0] pc [3];

  logic [EW-1:0]        e1 [3];
  logic [EW-1:0]        e2 [3];
  logic [SQW-1:0]       sq1 [3];
  logic [SQW-1:0]       sq2 [3];
  logic [SVW-1:0]       sv [3];
  logic [QW-1:0]        q4 [3];
  logic [QW-1:0]        q5 [3];
  logic [QW-1:0]        m5;
  logic [QW-1:0]        mc;
  logic [QW-1:0]        qc [3];
  logic [DVW-1:0]       mm;
  logic [DVW-1:0]       qs [3];
  logic [T_QBITS-1:0]   tq [3];
  logic [2*T_QBITS-1:0] tt [3];
  logic [UW-1:0]        u8 [3];
  logic [UW-1:0]        u9 [3];
  logic [SUMW-1:0]      usum;
  logic [W_QBITS-1:0]   wq [3];
  logic signed [PRW-1:0] prod [3];
  logic signed [ACW-1:0] acc;
  logic signed [PW-1:0] pd [PD][3];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      xv[i] = DW'(win[i]);
    end
    d1[0] = xv[0] - (xv[1] <<< 1) + xv[2];
    d2[0] = xv[0] - (xv[1] <<< 2) + DW'(3) * xv[2];
    d1[1] = xv[1] - (xv[2] <<< 1) + xv[3];
    d2[1] = xv[1] - xv[3];
    d1[2] = xv[2] - (xv[3] <<< 1) + xv[4];
    d2[2] = DW'(3) * xv[2] - (xv[3] <<< 2) + xv[4];
    pc[0] = PW'(DW'(3) * xv[0] - DW'(10) * xv[1] + DW'(15) * xv[2]);
    pc[1] = PW'(DW'(6) * xv[2] + DW'(3) * xv[3] - xv[1]);
    pc[2] = PW'(DW'(3) * xv[2] + DW'(6) * xv[3] - xv[4]);
    for (int k = 0; k < 3; k++) begin
      r1[k] = (d1[k] + DRND) >>> DS;
      r2[k] = (d2[k] + DRND) >>> DS;
      a1[k] = r1[k][DW-1] ? DW'(-r1[k]) : DW'(r1[k]);
      a2[k] = r2[k][DW-1] ? DW'(-r2[k]) : DW'(r2[k]);
    end
  end

  always_comb begin
    mc = m5;
    for (int k = 0; k < 3; k++) begin
      qc[k] = q5[k];
    end
    for (int j = 4; j >= 0; j--) begin
      if ((mc >> (32 + (1 << j))) != '0) begin
        mc = mc >> (1 << j);
        for (int k = 0; k < 3; k++) begin
          qc[k] = qc[k] >> (1 << j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= a1[k][EW-1:0];
        e2[k] <= a2[k][EW-1:0];
        sq1[k] <= e1[k] * e1[k];
        sq2[k] <= e2[k] * e2[k];
        sv[k] <= SVW'(sq1[k]) * SVW'(13) + SVW'(sq2[k]) * SVW'(3);
        q4[k] <= QW'(sv[k][SVW-1:18]) * QW'(BETA_K)
               + QW'((33'(sv[k][17:0]) * 33'(BETA_K)) >> 18) + EPS;
        q5[k] <= q4[k];
        qs[k] <= DVW'(qc[k]);
        tt[k] <= tq[k] * tq[k];
        u8[k] <= UW'(UW'(GAMMA[k]) * UW'(tt[k][2*T_QBITS-1:30]));
        u9[k] <= u8[k];
        prod[k] <= PRW'($signed({1'b0, wq[k]})) * PRW'(pd[PD-1][k]);
      end
      m5 <= (q4[0] < q4[1]) ? ((q4[0] < q4[2]) ? q4[0] : q4[2])
                            : ((q4[1] < q4[2]) ? q4[1] : q4[2]);
      mm <= DVW'(mc);
      usum <= SUMW'(u8[0]) + SUMW'(u8[1]) + SUMW'(u8[2]);
      acc <= ACW'(prod[0]) + ACW'(prod[1]) + ACW'(prod[2]) + ACW'(32768);
      pd[0] <= pc;
      for (int i = 1; i < PD; i++) begin
        pd[i] <= pd[i-1];
      end
    end
  end

  assign face = FW'(acc >>> 16);

  for (genvar k = 0; k < 3; k++) begin : g_div
    weno5_div #(.DENW(DVW), .QBITS(T_QBITS)) u_tdiv (
      .clk(clk), .en(en), .num(mm), .den(qs[k]), .quo(tq[k])
    );
    weno5_div #(.DENW(SUMW), .QBITS(W_QBITS)) u_wdiv (
      .clk(clk), .en(en), .num(SUMW'(u9[k])), .den(usum), .quo(wq[k])
    );
  end

endmodule
